@@ design/bta_pkg.sv @@
// Shared constants, codes and trit helpers for the balanced-ternary ALU.
package bta_pkg;

    // Default tryte width in trits
    localparam int TRITS_DEF = 9;

    // Operation codes
    localparam logic [3:0] MODE_ADD   = 4'd0;
    localparam logic [3:0] MODE_XOR   = 4'd1;
    localparam logic [3:0] MODE_AND   = 4'd2;
    localparam logic [3:0] MODE_NEG   = 4'd3;
    localparam logic [3:0] MODE_SHIFT = 4'd4;
    localparam logic [3:0] MODE_MUL   = 4'd5;
    localparam logic [3:0] MODE_DIV   = 4'd6;
    localparam logic [3:0] MODE_MOD   = 4'd7;
    localparam logic [3:0] MODE_COND  = 4'd8;

    // Carry modes
    localparam logic [1:0] CM_IN   = 2'b01;
    localparam logic [1:0] CM_FOLD = 2'b11;

    // Condition codes
    localparam logic signed [3:0] COND_SF_NOT_NEG = -4'sd4;
    localparam logic signed [3:0] COND_SF_NOT_ZER = -4'sd3;
    localparam logic signed [3:0] COND_SF_NOT_POS = -4'sd2;
    localparam logic signed [3:0] COND_CF_ZER     = -4'sd1;
    localparam logic signed [3:0] COND_ALWAYS     =  4'sd0;
    localparam logic signed [3:0] COND_CF_NOT_ZER =  4'sd1;
    localparam logic signed [3:0] COND_SF_NEG     =  4'sd2;
    localparam logic signed [3:0] COND_SF_ZER     =  4'sd3;
    localparam logic signed [3:0] COND_SF_POS     =  4'sd4;

    // Trit codes
    localparam logic [1:0] T_ZER = 2'b00;
    localparam logic [1:0] T_POS = 2'b01;
    localparam logic [1:0] T_NEG = 2'b11;

    // Signed binary width that holds any tryte value of the given length
    function automatic int bin_width(input int trits);
        longint p;
        longint m;
        int     w;
        p = 1;
        for (int i = 0; i < trits; i++) p = p * 3;
        m = (p - 1) / 2;
        w = 1;
        while ((longint'(1) << (w - 1)) <= m) w++;
        return w;
    endfunction

    // Trit code to integer; code 10 reads as zero
    function automatic int tv(input logic [1:0] t);
        return (t == T_POS) ? 1 : ((t == T_NEG) ? -1 : 0);
    endfunction

    // Integer in -1..1 to trit code
    function automatic logic [1:0] te(input int v);
        return (v > 0) ? T_POS : ((v < 0) ? T_NEG : T_ZER);
    endfunction

    // Negate one trit code
    function automatic logic [1:0] tneg(input logic [1:0] t);
        return {t[1] ^ t[0], t[0]};
    endfunction

endpackage

@@ design/balanced_ternary_alu.sv @@
// Balanced-ternary ALU top level: sequenced trit and bit serial datapath.
// One operation per beat, one result per beat. Add, xor, and, negate, the
// condition test and unused modes pass through dispatch and done to the result.
// Multiply is a shift-and-add over the trits of operand_b.
// Shift converts the count to binary and then moves one trit a cycle; a
// count out of range skips the move and gives a zero result.
// Divide and remainder convert both operands, run a restoring divider
// one quotient bit a cycle (M = magnitude bits of a tryte, 14 for nine
// trits) and convert back one bit a cycle. A finished result waits in
// the output register while the next beat is taken.
module balanced_ternary_alu #(
    parameter int TRITS = bta_pkg::TRITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [3:0]             i_mode,
    input  logic [2*TRITS-1:0]     i_operand_a,
    input  logic [2*TRITS-1:0]     i_operand_b,
    input  logic                   i_subtract,
    input  logic signed [1:0]      i_carry_mode,
    input  logic                   i_shift_right,
    input  logic signed [3:0]      i_condition,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [2*TRITS-1:0]     o_result,
    output logic signed [1:0]      o_sign_flag,
    output logic signed [1:0]      o_carry_flag,
    output logic                   o_divide_by_zero,
    output logic                   o_condition_met
);

    localparam int TW = 2 * TRITS;
    localparam int W  = bta_pkg::bin_width(TRITS);
    localparam int M  = W - 1;
    localparam int CW = $clog2(M + 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DISP  = 4'd1;
    localparam logic [3:0] S_MUL   = 4'd2;
    localparam logic [3:0] S_CONV  = 4'd3;
    localparam logic [3:0] S_POST  = 4'd4;
    localparam logic [3:0] S_SHIFT = 4'd5;
    localparam logic [3:0] S_DIV   = 4'd6;
    localparam logic [3:0] S_DIVF  = 4'd7;
    localparam logic [3:0] S_TOBT  = 4'd8;
    localparam logic [3:0] S_FIN   = 4'd9;
    localparam logic [3:0] S_DONE  = 4'd10;

    // Tryte add with carry in; returns {carry out, sum}
    function automatic logic [TW+1:0] add_tr(input logic [TW-1:0] x,
                                             input logic [TW-1:0] y,
                                             input logic [1:0]    cin);
        int             c;
        int             s;
        logic [TW-1:0]  d;
        c = bta_pkg::tv(cin);
        d = '0;
        for (int i = 0; i < TRITS; i++) begin
            s = c + bta_pkg::tv(x[2*i +: 2]) + bta_pkg::tv(y[2*i +: 2]);
            if (s < -1) begin
                s = s + 3;
                c = -1;
            end else if (s > 1) begin
                s = s - 3;
                c = 1;
            end else begin
                c = 0;
            end
            d[2*i +: 2] = bta_pkg::te(s);
        end
        return {bta_pkg::te(c), d};
    endfunction

    function automatic logic [TW-1:0] neg_tr(input logic [TW-1:0] x);
        logic [TW-1:0] d;
        for (int i = 0; i < TRITS; i++) d[2*i +: 2] = bta_pkg::tneg(x[2*i +: 2]);
        return d;
    endfunction

    // Most significant nonzero trit
    function automatic logic [1:0] top_tr(input logic [TW-1:0] x);
        logic [1:0] s;
        s = bta_pkg::T_ZER;
        for (int i = 0; i < TRITS; i++) if (x[2*i +: 2] != bta_pkg::T_ZER) s = x[2*i +: 2];
        return s;
    endfunction

    function automatic logic [TW-1:0] norm_tr(input logic [TW-1:0] x);
        logic [TW-1:0] d;
        for (int i = 0; i < TRITS; i++) d[2*i +: 2] = {x[2*i+1] & x[2*i], x[2*i]};
        return d;
    endfunction

    logic [3:0]           r_state, n_state;
    logic [3:0]           r_mode;
    logic [TW-1:0]        r_a, n_a;
    logic [TW-1:0]        r_b, n_b;
    logic                 r_sub, r_shr;
    logic [1:0]           r_cm;
    logic signed [3:0]    r_cond;
    logic [1:0]           r_sf, n_sf, r_cf, n_cf;
    logic [TW-1:0]        r_acc, n_acc;
    logic [1:0]           r_wsf, n_wsf, r_wcf, n_wcf;
    logic                 r_dbz, n_dbz, r_met, n_met;
    logic signed [W-1:0]  r_va, n_va, r_vb, n_vb;
    logic [M-1:0]         r_quo, n_quo, r_rem, n_rem, r_den, n_den;
    logic                 r_neg, n_neg, r_left, n_left;
    logic [CW-1:0]        r_cnt, n_cnt;
    logic                 r_ovalid, n_ovalid;
    logic [TW-1:0]        r_ores, n_ores;
    logic [1:0]           r_osf, n_osf, r_ocf, n_ocf;
    logic                 r_odbz, n_odbz, r_omet, n_omet;

    logic                 accept;
    logic [TW+1:0]        add_res;
    logic [TW-1:0]        b_eff;
    logic [1:0]           cin;
    logic [TW-1:0]        mul_add;
    logic [1:0]           b_top;
    logic [M:0]           rem_sh, rem_diff;
    logic signed [W-1:0]  shcnt, shabs;
    int                   cfold;

    assign accept  = i_valid && o_ready;
    assign o_ready = (r_state == S_IDLE);

    // Add operand selection and carry in
    assign b_eff = r_sub ? neg_tr(r_b) : r_b;
    assign cin   = (r_cm == bta_pkg::CM_IN) ? r_cf : bta_pkg::T_ZER;

    // Multiply step addend from the top trit of b
    assign b_top   = r_b[TW-1 -: 2];
    assign mul_add = (b_top == bta_pkg::T_POS) ? r_a :
                     ((b_top == bta_pkg::T_NEG) ? neg_tr(r_a) : '0);

    // Restoring divide step
    assign rem_sh   = {r_rem, r_quo[M-1]};
    assign rem_diff = rem_sh - {1'b0, r_den};

    // Signed shift count
    assign shcnt = r_shr ? -r_vb : r_vb;
    assign shabs = shcnt[W-1] ? -shcnt : shcnt;

    always_comb begin
        n_state  = r_state;
        n_a      = r_a;
        n_b      = r_b;
        n_sf     = r_sf;
        n_cf     = r_cf;
        n_acc    = r_acc;
        n_wsf    = r_wsf;
        n_wcf    = r_wcf;
        n_dbz    = r_dbz;
        n_met    = r_met;
        n_va     = r_va;
        n_vb     = r_vb;
        n_quo    = r_quo;
        n_rem    = r_rem;
        n_den    = r_den;
        n_neg    = r_neg;
        n_left   = r_left;
        n_cnt    = r_cnt;
        n_ovalid = r_ovalid;
        n_ores   = r_ores;
        n_osf    = r_osf;
        n_ocf    = r_ocf;
        n_odbz   = r_odbz;
        n_omet   = r_omet;
        add_res  = '0;
        cfold    = 0;

        if (r_ovalid && i_ready) n_ovalid = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_a     = norm_tr(i_operand_a);
                    n_b     = norm_tr(i_operand_b);
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                n_acc = '0;
                n_wsf = r_sf;
                n_wcf = r_cf;
                n_dbz = 1'b0;
                n_met = 1'b0;
                n_cnt = CW'(TRITS);
                n_va  = '0;
                n_vb  = '0;
                n_state = S_DONE;
                unique case (r_mode)
                    bta_pkg::MODE_ADD: begin
                        add_res = add_tr(r_a, b_eff, cin);
                        n_acc   = add_res[TW-1:0];
                        cfold   = bta_pkg::tv(add_res[TW+1:TW]);
                        if (r_cm == bta_pkg::CM_FOLD) begin
                            cfold = cfold + bta_pkg::tv(r_cf);
                            if (cfold < -1) cfold = cfold + 3;
                            if (cfold > 1)  cfold = cfold - 3;
                        end
                        n_wcf = bta_pkg::te(cfold);
                        n_wsf = (cfold != 0) ? bta_pkg::te(cfold) : top_tr(add_res[TW-1:0]);
                    end
                    bta_pkg::MODE_XOR, bta_pkg::MODE_AND, bta_pkg::MODE_NEG: begin
                        for (int i = 0; i < TRITS; i++) begin
                            if (r_mode == bta_pkg::MODE_XOR) begin
                                cfold = bta_pkg::tv(r_a[2*i +: 2]) + bta_pkg::tv(r_b[2*i +: 2]);
                                if (cfold > 1)  cfold = cfold - 3;
                                if (cfold < -1) cfold = cfold + 3;
                            end else if (r_mode == bta_pkg::MODE_AND) begin
                                cfold = bta_pkg::tv(r_a[2*i +: 2]) * bta_pkg::tv(r_b[2*i +: 2]);
                            end else begin
                                cfold = -bta_pkg::tv(r_a[2*i +: 2]);
                            end
                            n_acc[2*i +: 2] = bta_pkg::te(cfold);
                        end
                        n_wsf = top_tr(n_acc);
                        n_wcf = bta_pkg::T_ZER;
                    end
                    bta_pkg::MODE_MUL: begin
                        n_wsf   = bta_pkg::te(bta_pkg::tv(top_tr(r_a)) * bta_pkg::tv(top_tr(r_b)));
                        n_wcf   = bta_pkg::T_ZER;
                        n_state = S_MUL;
                    end
                    bta_pkg::MODE_SHIFT, bta_pkg::MODE_DIV, bta_pkg::MODE_MOD: begin
                        n_state = S_CONV;
                    end
                    bta_pkg::MODE_COND: begin
                        unique case (r_cond)
                            bta_pkg::COND_SF_NOT_NEG: n_met = (r_sf != bta_pkg::T_NEG);
                            bta_pkg::COND_SF_NOT_ZER: n_met = (r_sf != bta_pkg::T_ZER);
                            bta_pkg::COND_SF_NOT_POS: n_met = (r_sf != bta_pkg::T_POS);
                            bta_pkg::COND_CF_ZER:     n_met = (r_cf == bta_pkg::T_ZER);
                            bta_pkg::COND_ALWAYS:     n_met = 1'b1;
                            bta_pkg::COND_CF_NOT_ZER: n_met = (r_cf != bta_pkg::T_ZER);
                            bta_pkg::COND_SF_NEG:     n_met = (r_sf == bta_pkg::T_NEG);
                            bta_pkg::COND_SF_ZER:     n_met = (r_sf == bta_pkg::T_ZER);
                            bta_pkg::COND_SF_POS:     n_met = (r_sf == bta_pkg::T_POS);
                            default:                  n_met = 1'b0;
                        endcase
                    end
                    default: ;
                endcase
            end
            // acc = 3*acc + a*b_top, b moves up one trit a cycle
            S_MUL: begin
                add_res = add_tr({r_acc[TW-3:0], bta_pkg::T_ZER}, mul_add, bta_pkg::T_ZER);
                n_acc   = add_res[TW-1:0];
                n_b     = {r_b[TW-3:0], bta_pkg::T_ZER};
                n_cnt   = r_cnt - 1'b1;
                if (r_cnt == CW'(1)) n_state = S_DONE;
            end
            // Ternary to binary, top trit first; trytes rotate back in place
            S_CONV: begin
                n_va  = (r_va <<< 1) + r_va + W'(bta_pkg::tv(r_a[TW-1 -: 2]));
                n_vb  = (r_vb <<< 1) + r_vb + W'(bta_pkg::tv(r_b[TW-1 -: 2]));
                n_a   = {r_a[TW-3:0], r_a[TW-1 -: 2]};
                n_b   = {r_b[TW-3:0], r_b[TW-1 -: 2]};
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == CW'(1)) n_state = S_POST;
            end
            S_POST: begin
                n_wcf = bta_pkg::T_ZER;
                if (r_mode == bta_pkg::MODE_SHIFT) begin
                    n_left = !shcnt[W-1];
                    if (shabs >= W'(TRITS)) begin
                        n_acc   = '0;
                        n_wsf   = bta_pkg::T_ZER;
                        n_state = S_DONE;
                    end else begin
                        n_cnt   = shabs[CW-1:0];
                        n_state = S_SHIFT;
                    end
                end else if (r_vb == '0) begin
                    n_dbz   = 1'b1;
                    n_wcf   = r_cf;
                    n_state = S_DONE;
                end else begin
                    n_quo   = r_va[W-1] ? M'(-r_va) : M'(r_va);
                    n_den   = r_vb[W-1] ? M'(-r_vb) : M'(r_vb);
                    n_rem   = '0;
                    n_cnt   = CW'(M);
                    n_state = S_DIV;
                end
            end
            S_SHIFT: begin
                if (r_cnt == '0) begin
                    n_acc   = r_a;
                    n_wsf   = top_tr(r_a);
                    n_state = S_DONE;
                end else begin
                    n_a   = r_left ? {r_a[TW-3:0], bta_pkg::T_ZER}
                                   : {bta_pkg::T_ZER, r_a[TW-1:2]};
                    n_cnt = r_cnt - 1'b1;
                end
            end
            S_DIV: begin
                if (!rem_diff[M]) begin
                    n_rem = rem_diff[M-1:0];
                    n_quo = {r_quo[M-2:0], 1'b1};
                end else begin
                    n_rem = rem_sh[M-1:0];
                    n_quo = {r_quo[M-2:0], 1'b0};
                end
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == CW'(1)) n_state = S_DIVF;
            end
            // Pick quotient or remainder; magnitude is rebuilt in ternary
            S_DIVF: begin
                if (r_mode == bta_pkg::MODE_DIV) begin
                    n_neg = r_va[W-1] ^ r_vb[W-1];
                end else begin
                    n_quo = r_rem;
                    n_neg = r_va[W-1];
                end
                n_acc   = '0;
                n_cnt   = CW'(M);
                n_state = S_TOBT;
            end
            // Binary to ternary: acc = 2*acc + bit, top bit first
            S_TOBT: begin
                add_res = add_tr(r_acc, r_acc, r_quo[M-1] ? bta_pkg::T_POS : bta_pkg::T_ZER);
                n_acc   = add_res[TW-1:0];
                n_quo   = {r_quo[M-2:0], 1'b0};
                n_cnt   = r_cnt - 1'b1;
                if (r_cnt == CW'(1)) n_state = S_FIN;
            end
            S_FIN: begin
                n_acc   = r_neg ? neg_tr(r_acc) : r_acc;
                n_wsf   = top_tr(n_acc);
                n_state = S_DONE;
            end
            // Commit flags and hand the beat to the output register
            S_DONE: begin
                if (!r_ovalid || i_ready) begin
                    n_ovalid = 1'b1;
                    n_ores   = r_acc;
                    n_osf    = r_wsf;
                    n_ocf    = r_wcf;
                    n_odbz   = r_dbz;
                    n_omet   = r_met;
                    n_sf     = r_wsf;
                    n_cf     = r_wcf;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_sf     <= bta_pkg::T_ZER;
            r_cf     <= bta_pkg::T_ZER;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_sf     <= n_sf;
            r_cf     <= n_cf;
            r_ovalid <= n_ovalid;
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode <= i_mode;
            r_sub  <= i_subtract;
            r_cm   <= i_carry_mode;
            r_shr  <= i_shift_right;
            r_cond <= i_condition;
        end
        r_a    <= n_a;
        r_b    <= n_b;
        r_acc  <= n_acc;
        r_wsf  <= n_wsf;
        r_wcf  <= n_wcf;
        r_dbz  <= n_dbz;
        r_met  <= n_met;
        r_va   <= n_va;
        r_vb   <= n_vb;
        r_quo  <= n_quo;
        r_rem  <= n_rem;
        r_den  <= n_den;
        r_neg  <= n_neg;
        r_left <= n_left;
        r_cnt  <= n_cnt;
        r_ores <= n_ores;
        r_osf  <= n_osf;
        r_ocf  <= n_ocf;
        r_odbz <= n_odbz;
        r_omet <= n_omet;
    end

    assign o_valid          = r_ovalid;
    assign o_result         = r_ores;
    assign o_sign_flag      = r_osf;
    assign o_carry_flag     = r_ocf;
    assign o_divide_by_zero = r_odbz;
    assign o_condition_met  = r_omet;

endmodule

@@ design/bta_checker.sv @@
// Port-level checks for the balanced-ternary ALU, bound to the top level.
module bta_checker #(
    parameter int TRITS = bta_pkg::TRITS_DEF
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_valid,
    input logic                   o_ready,
    input logic                   o_valid,
    input logic                   i_ready,
    input logic [2*TRITS-1:0]     o_result,
    input logic signed [1:0]      o_sign_flag,
    input logic signed [1:0]      o_carry_flag,
    input logic                   o_divide_by_zero,
    input logic                   o_condition_met
);

    // No result beat right after reset
    a_rst_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // An accepted input beat keeps the block busy for the next cycle
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("ready right after input beat");

    // A stalled result beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_result) && $stable(o_sign_flag))
        else $error("stalled result changed");

    // A divide by zero or a met condition gives an empty result, never both at once
    a_dbz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_divide_by_zero || o_condition_met) |->
            o_result == '0 && !(o_divide_by_zero && o_condition_met))
        else $error("error or test beat with data");

    // Flag trits never carry the unused code
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_sign_flag != 2'b10 && o_carry_flag != 2'b10)
        else $error("bad flag trit code");

endmodule

bind balanced_ternary_alu bta_checker #(.TRITS(TRITS)) u_bta_checker (.*);
